@@ design/normalization_cube_texel_top_defines.svh @@
// Assertion macros shared by the normalization cube texel RTL
`ifndef NORMALIZATION_CUBE_TEXEL_TOP_DEFINES_SVH
`define NORMALIZATION_CUBE_TEXEL_TOP_DEFINES_SVH

// Invariant checked at every clock edge outside reset
`define NCT_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication checked outside reset
`define NCT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/ncube_pkg.sv @@
// Shared types, constants and step functions of the normalization cube texel block
`timescale 1ns / 1ps
package ncube_pkg;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam int CDIV_STEPS  = 18;
	localparam int CDIV_PER    = 3;
	localparam int CDIV_STAGES = CDIV_STEPS / CDIV_PER;
	localparam int SQRT_STEPS  = 18;
	localparam int SQRT_PER    = 3;
	localparam int SQRT_STAGES = SQRT_STEPS / SQRT_PER;
	localparam int ENC_STEPS   = 8;
	localparam int ENC_PER     = 2;
	localparam int ENC_STAGES  = ENC_STEPS / ENC_PER;

	typedef logic signed [17:0] comp_t;

	localparam comp_t C_ONE  = 18'sd65536;
	localparam comp_t C_MONE = -18'sd65536;

	typedef struct packed {
		logic [10:0] rem;
		logic [17:0] quo;
	} cdiv_t;

	typedef struct packed {
		logic [2:0] face;
		cdiv_t      du;
		cdiv_t      dv;
		logic       lu;
		logic       lv;
	} coord_t;

	typedef struct packed {
		logic  bad;
		comp_t cx;
		comp_t cy;
		comp_t cz;
	} dir_t;

	typedef struct packed {
		logic [18:0] rem;
		logic [17:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic        bad;
		comp_t       cx;
		comp_t       cy;
		comp_t       cz;
		logic [35:0] sq;
		sqrt_st_t    st;
	} sqrt_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [7:0]  quo;
		logic [7:0]  lo;
	} enc_lane_t;

	typedef struct packed {
		logic                  bad;
		logic [17:0]           den;
		enc_lane_t [2:0]       lane;
	} enc_t;

	// bit fed into the texel-centre division: texel lsb, then the +1, then zeros
	function automatic logic cdiv_bit(input int idx, input logic lsb);
		logic b;
		b = (idx == 0) ? lsb : (idx == 1);
		return b;
	endfunction

	function automatic cdiv_t cdiv_step(input cdiv_t s, input logic b, input logic [10:0] d);
		logic [11:0] r2;
		cdiv_t       o;
		r2 = {s.rem, b};
		if (r2 >= {1'b0, d}) begin
			o.rem = 11'(r2 - {1'b0, d});
			o.quo = {s.quo[16:0], 1'b1};
		end else begin
			o.rem = r2[10:0];
			o.quo = {s.quo[16:0], 1'b0};
		end
		return o;
	endfunction

	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] p);
		logic [20:0] r2;
		logic [20:0] t;
		sqrt_st_t    o;
		r2 = {s.rem, p};
		t  = {1'b0, s.root, 2'b01};
		if (r2 >= t) begin
			o.rem  = 19'(r2 - t);
			o.root = {s.root[16:0], 1'b1};
		end else begin
			o.rem  = r2[18:0];
			o.root = {s.root[16:0], 1'b0};
		end
		return o;
	endfunction

	function automatic enc_lane_t enc_step(input enc_lane_t s, input logic b,
			input logic [17:0] d);
		logic [18:0] r2;
		enc_lane_t   o;
		r2    = {s.rem, b};
		o.lo  = s.lo;
		if (r2 >= {1'b0, d}) begin
			o.rem = 18'(r2 - {1'b0, d});
			o.quo = {s.quo[6:0], 1'b1};
		end else begin
			o.rem = r2[17:0];
			o.quo = {s.quo[6:0], 1'b0};
		end
		return o;
	endfunction

	// face orientation: direction from face code and centred u, v
	function automatic dir_t face_dir(input logic [2:0] face, input comp_t u, input comp_t v);
		dir_t d;
		d.bad = 1'b0;
		d.cx  = '0;
		d.cy  = '0;
		d.cz  = '0;
		case (face)
			FACE_PX: begin
				d.cx = C_ONE;  d.cy = -v;     d.cz = -u;
			end
			FACE_NX: begin
				d.cx = C_MONE; d.cy = -v;     d.cz = u;
			end
			FACE_PY: begin
				d.cx = u;      d.cy = C_ONE;  d.cz = v;
			end
			FACE_NY: begin
				d.cx = u;      d.cy = C_MONE; d.cz = -v;
			end
			FACE_PZ: begin
				d.cx = u;      d.cy = -v;     d.cz = C_ONE;
			end
			FACE_NZ: begin
				d.cx = -u;     d.cy = -v;     d.cz = C_MONE;
			end
			default: begin
				d.bad = 1'b1;
			end
		endcase
		return d;
	endfunction

endpackage

@@ design/ncube_ifs.sv @@
// Request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface ncube_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] face;
	logic [9:0] texel_x;
	logic [9:0] texel_y;
	modport source (output valid, face, texel_x, texel_y, input ready);
	modport sink (input valid, face, texel_x, texel_y, output ready);
endinterface

interface ncube_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface ncube_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] side_size;
	modport source (output valid, side_size, input ready);
	modport sink (input valid, side_size, output ready);
endinterface

@@ design/ncube_coord.sv @@
// Pipelined texel-centre divider producing u and v quotients
`timescale 1ns / 1ps
`include "normalization_cube_texel_top_defines.svh"
module ncube_coord import ncube_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  coord_t      din,
	input  logic [10:0] side,
	output logic        out_vld,
	output coord_t      dout
);
	localparam int NS = CDIV_STAGES;

	coord_t          stg_s [NS];
	coord_t          nxt_w [NS];
	logic [NS-1:0]   vld_s;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		coord_t src;
		coord_t nx;
		if (j == 0) begin : g_head
			assign src = din;
		end else begin : g_body
			assign src = stg_s[j-1];
		end
		always_comb begin
			nx = src;
			for (int k = 0; k < CDIV_PER; k++) begin
				nx.du = cdiv_step(nx.du, cdiv_bit(j * CDIV_PER + k, src.lu), side);
				nx.dv = cdiv_step(nx.dv, cdiv_bit(j * CDIV_PER + k, src.lv), side);
			end
		end
		assign nxt_w[j] = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NS; j++) begin
				stg_s[j] <= nxt_w[j];
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign dout    = stg_s[NS-1];

	`NCT_IMPLY(a_coord_bounds, out_vld, (dout.du.rem < side) && (dout.dv.rem < side) && !dout.du.quo[17] && !dout.dv.quo[17], "texel divider left an out-of-range remainder or quotient")
endmodule

@@ design/ncube_isqrt.sv @@
// Pipelined digit-by-digit integer square root of the squared length
`timescale 1ns / 1ps
`include "normalization_cube_texel_top_defines.svh"
module ncube_isqrt import ncube_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_vld,
	input  sqrt_t din,
	output logic  out_vld,
	output sqrt_t dout
);
	localparam int NS = SQRT_STAGES;

	sqrt_t         stg_s [NS];
	sqrt_t         nxt_w [NS];
	logic [NS-1:0] vld_s;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		sqrt_t src;
		sqrt_t nx;
		if (j == 0) begin : g_head
			assign src = din;
		end else begin : g_body
			assign src = stg_s[j-1];
		end
		always_comb begin
			nx = src;
			for (int k = 0; k < SQRT_PER; k++) begin
				nx.st = sqrt_step(nx.st, src.sq[35 - 2 * (j * SQRT_PER + k) -: 2]);
			end
		end
		assign nxt_w[j] = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NS; j++) begin
				stg_s[j] <= nxt_w[j];
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign dout    = stg_s[NS-1];

	`NCT_IMPLY(a_root_floor, out_vld, (36'(dout.st.root) * 36'(dout.st.root) <= dout.sq) && (36'(dout.st.root + 18'd1) * 36'(dout.st.root + 18'd1) > dout.sq), "square root is not the floor root")
endmodule

@@ design/ncube_enc.sv @@
// Pipelined three-lane byte encoder: floor(255*(len+c) / (2*len))
`timescale 1ns / 1ps
`include "normalization_cube_texel_top_defines.svh"
module ncube_enc import ncube_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_vld,
	input  enc_t din,
	output logic out_vld,
	output enc_t dout
);
	localparam int NS = ENC_STAGES;

	enc_t          stg_s [NS];
	enc_t          nxt_w [NS];
	logic [NS-1:0] vld_s;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		enc_t src;
		enc_t nx;
		if (j == 0) begin : g_head
			assign src = din;
		end else begin : g_body
			assign src = stg_s[j-1];
		end
		always_comb begin
			nx = src;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < ENC_PER; k++) begin
					nx.lane[i] = enc_step(nx.lane[i],
						src.lane[i].lo[7 - (j * ENC_PER + k)], src.den);
				end
			end
		end
		assign nxt_w[j] = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NS; j++) begin
				stg_s[j] <= nxt_w[j];
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign dout    = stg_s[NS-1];

	`NCT_IMPLY(a_enc_rem, out_vld && !dout.bad, (dout.lane[0].rem < dout.den) && (dout.lane[1].rem < dout.den) && (dout.lane[2].rem < dout.den), "encoder remainder not below divisor")
endmodule

@@ design/normalization_cube_texel_top.sv @@
// Normalization cube map texel generator: face and texel in, encoded unit direction out.
// Throughput: one beat per cycle while no response beat is stalled;
// each divider and the square root are unrolled over stages.
// A stalled response beat freezes the whole pipe; request ready is low only then.
// Reset clears every valid bit and loads side_size with 64 (clamped to MAX_SIDE).
`timescale 1ns / 1ps
`include "normalization_cube_texel_top_defines.svh"
module normalization_cube_texel_top import ncube_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ncube_req_if.sink   req,
	ncube_rsp_if.source rsp,
	ncube_cfg_if.sink   cfg
);
	localparam logic [10:0] SIDE_RST = (MAX_SIDE < 64) ? 11'(MAX_SIDE) : 11'd64;

	// effective side size, already clamped to 1..MAX_SIDE
	logic [10:0] side_q;

	// pipe advance: every stage moves together when the output register can take a beat
	logic adv;

	// front stage: face and saturated texel coordinates
	logic        vld_s1;
	logic [2:0]  face_s1;
	logic [9:0]  tx_s1;
	logic [9:0]  ty_s1;
	logic [9:0]  tx_sat;
	logic [9:0]  ty_sat;

	coord_t      coord_in;
	coord_t      coord_out;
	logic        coord_vld;

	comp_t       u_w;
	comp_t       v_w;
	dir_t        dir_w;
	logic signed [35:0] prx_w;
	logic signed [35:0] pry_w;
	logic signed [35:0] prz_w;

	// squares stage
	logic        vld_s8;
	dir_t        dir_s8;
	logic [32:0] sqx_s8;
	logic [32:0] sqy_s8;
	logic [32:0] sqz_s8;

	// radicand stage
	logic        vld_s9;
	sqrt_t       rad_s9;
	logic [33:0] sum_w;

	sqrt_t       sqrt_out;
	logic        sqrt_vld;

	// encoder set-up stage
	logic        vld_s16;
	enc_t        enc_s16;
	enc_t        enc_w;

	enc_t        enc_out;
	logic        enc_vld;

	// output register
	logic        out_vld_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	// ---------------------------------------------------------------- configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RST;
		end else if (cfg.valid) begin
			if (cfg.side_size == 11'd0) begin
				side_q <= 11'd1;
			end else if ({2'b0, cfg.side_size} > 13'(MAX_SIDE)) begin
				side_q <= 11'(MAX_SIDE);
			end else begin
				side_q <= cfg.side_size;
			end
		end
	end

	// ---------------------------------------------------------------- front stage
	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	// hold a coordinate at the last texel of the face when it runs past the edge
	assign tx_sat = ({1'b0, req.texel_x} >= side_q) ? 10'(side_q - 11'd1) : req.texel_x;
	assign ty_sat = ({1'b0, req.texel_y} >= side_q) ? 10'(side_q - 11'd1) : req.texel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			face_s1 <= req.face;
			tx_s1   <= tx_sat;
			ty_s1   <= ty_sat;
		end
	end

	// ---------------------------------------------------------------- u, v division
	// (2t+1)*65536/side: start the remainder at t>>1, then feed t[0], the +1 and 16 zeros
	always_comb begin
		coord_in.face   = face_s1;
		coord_in.du.rem = {2'b0, tx_s1[9:1]};
		coord_in.du.quo = '0;
		coord_in.dv.rem = {2'b0, ty_s1[9:1]};
		coord_in.dv.quo = '0;
		coord_in.lu     = tx_s1[0];
		coord_in.lv     = ty_s1[0];
	end

	ncube_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.din     (coord_in),
		.side    (side_q),
		.out_vld (coord_vld),
		.dout    (coord_out)
	);

	// ---------------------------------------------------------------- direction and squares
	assign u_w   = $signed(coord_out.du.quo) - C_ONE;
	assign v_w   = $signed(coord_out.dv.quo) - C_ONE;
	assign dir_w = face_dir(coord_out.face, u_w, v_w);
	assign prx_w = dir_w.cx * dir_w.cx;
	assign pry_w = dir_w.cy * dir_w.cy;
	assign prz_w = dir_w.cz * dir_w.cz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= coord_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s8 <= dir_w;
			sqx_s8 <= prx_w[32:0];
			sqy_s8 <= pry_w[32:0];
			sqz_s8 <= prz_w[32:0];
		end
	end

	// ---------------------------------------------------------------- squared length
	assign sum_w = {1'b0, sqx_s8} + {1'b0, sqy_s8} + {1'b0, sqz_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s9.bad <= dir_s8.bad;
			rad_s9.cx  <= dir_s8.cx;
			rad_s9.cy  <= dir_s8.cy;
			rad_s9.cz  <= dir_s8.cz;
			rad_s9.sq  <= {2'b0, sum_w};
			rad_s9.st  <= '0;
		end
	end

	ncube_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s9),
		.din     (rad_s9),
		.out_vld (sqrt_vld),
		.dout    (sqrt_out)
	);

	// ---------------------------------------------------------------- encoder set-up
	// for the six valid face codes the length never drops below one (Q16), so len+c stays in 0..2*len
	always_comb begin
		logic signed [18:0] a;
		logic [17:0]        au;
		logic [25:0]        num;
		comp_t              c;
		enc_w.bad = sqrt_out.bad;
		enc_w.den = {sqrt_out.st.root[16:0], 1'b0};
		for (int i = 0; i < 3; i++) begin
			c   = (i == 0) ? sqrt_out.cx : ((i == 1) ? sqrt_out.cy : sqrt_out.cz);
			a   = $signed({2'b0, sqrt_out.st.root[16:0]}) + $signed({c[17], c});
			au  = a[17:0];
			num = {au, 8'b0} - {8'b0, au};
			enc_w.lane[i].rem = num[25:8];
			enc_w.lane[i].lo  = num[7:0];
			enc_w.lane[i].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else if (adv) begin
			vld_s16 <= sqrt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			enc_s16 <= enc_w;
		end
	end

	ncube_enc u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s16),
		.din     (enc_s16),
		.out_vld (enc_vld),
		.dout    (enc_out)
	);

	// ---------------------------------------------------------------- output register
	// drop the colour to zero for the two unused face codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= enc_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= enc_out.bad ? 8'd0 : enc_out.lane[0].quo;
			green_q <= enc_out.bad ? 8'd0 : enc_out.lane[1].quo;
			blue_q  <= enc_out.bad ? 8'd0 : enc_out.lane[2].quo;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.red   = red_q;
	assign rsp.green = green_q;
	assign rsp.blue  = blue_q;
	assign rsp.alpha = 8'd0;

	`NCT_CHECK(a_side_range, (side_q != 11'd0) && ({2'b0, side_q} <= 13'(MAX_SIDE)), "side size register left its clamped range")
endmodule
